@@ hw/rtl/set_assoc_lru_cache_sim_defines.svh @@
// Assertion macros for the LRU cache simulator checker.
// Included by salc_checker.sv; needs clk_i and rst_ni in scope.
`ifndef SET_ASSOC_LRU_CACHE_SIM_DEFINES_SVH
`define SET_ASSOC_LRU_CACHE_SIM_DEFINES_SVH

// Property checked on every rising clock edge outside reset.
`define SALC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Condition that must never be seen outside reset.
`define SALC_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);

`endif

@@ hw/rtl/salc_pkg.sv @@
// Shared types and constants for the set-associative LRU cache simulator.
// No dependencies; imported by every RTL module of the block.
`timescale 1ns / 1ps

package salc_pkg;

  // Item field layout
  localparam int ACTION_W    = 2;
  localparam int ADDR_W      = 32;
  localparam int IN_ADDR_LSB = ACTION_W;
  localparam int IN_TDATA_W  = 40;   // 34 bits of fields, padded to bytes

  localparam int HITS_W      = 2;
  localparam int SUM_W       = 32;
  localparam int OUT_TDATA_W = 104;  // 100 bits of fields, padded to bytes

  // Config registers
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 5;
  localparam int SET_BITS_W  = 3;
  localparam int WAYS_CFG_W  = 4;
  localparam int BLK_BITS_W  = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WAYS       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BITS = 2'd2;

  // Recency rank
  localparam int                AGE_W   = 3;
  localparam logic [AGE_W-1:0]  AGE_MAX = 3'd7;

  typedef enum logic [ACTION_W-1:0] {
    ACT_LOAD   = 2'd0,
    ACT_STORE  = 2'd1,
    ACT_MODIFY = 2'd2,
    ACT_NONE   = 2'd3
  } salc_action_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } salc_state_e;

  // Outcome of one lookup
  typedef struct packed {
    logic hit;
    logic evict;
  } salc_stat_t;

  function automatic logic [AGE_W-1:0] age_inc(input logic [AGE_W-1:0] a);
    age_inc = (a == AGE_MAX) ? a : a + AGE_W'(1);
  endfunction

endpackage

@@ hw/rtl/salc_row_store.sv @@
// Set row memory: valid, tag and rank of every way of one set per row.
// One write port, one read port, registered read data. Uses salc_pkg.
`timescale 1ns / 1ps

module salc_row_store
  import salc_pkg::*;
#(
  parameter int ROWS   = 64,
  parameter int IDX_W  = 6,
  parameter int WAYS   = 8,
  parameter int TAG_W  = 32
) (
  input  logic                            clk_i,
  input  logic                            rd_en_i,
  input  logic [IDX_W-1:0]                rd_addr_i,
  input  logic                            wr_en_i,
  input  logic [IDX_W-1:0]                wr_addr_i,
  input  logic [WAYS-1:0]                 wr_valid_i,
  input  logic [WAYS-1:0][TAG_W-1:0]      wr_tag_i,
  input  logic [WAYS-1:0][AGE_W-1:0]      wr_age_i,
  output logic [WAYS-1:0]                 rd_valid_o,
  output logic [WAYS-1:0][TAG_W-1:0]      rd_tag_o,
  output logic [WAYS-1:0][AGE_W-1:0]      rd_age_o
);

  logic [WAYS-1:0]            mem_valid [ROWS];
  logic [WAYS-1:0][TAG_W-1:0] mem_tag   [ROWS];
  logic [WAYS-1:0][AGE_W-1:0] mem_age   [ROWS];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_valid[wr_addr_i] <= wr_valid_i;
      mem_tag[wr_addr_i]   <= wr_tag_i;
      mem_age[wr_addr_i]   <= wr_age_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_valid_o <= mem_valid[rd_addr_i];
      rd_tag_o   <= mem_tag[rd_addr_i];
      rd_age_o   <= mem_age[rd_addr_i];
    end
  end

endmodule

@@ hw/rtl/salc_lru_update.sv @@
// Lookup and LRU update of one set row: hit search, victim pick, rank ageing.
// Pure combinational; uses salc_pkg.
`timescale 1ns / 1ps

module salc_lru_update
  import salc_pkg::*;
#(
  parameter int WAYS   = 8,
  parameter int TAG_W  = 32,
  parameter int WCNT_W = 4
) (
  input  logic                        access_i,
  input  logic [TAG_W-1:0]            tag_i,
  input  logic [WCNT_W-1:0]           ways_i,
  input  logic [WAYS-1:0]             row_valid_i,
  input  logic [WAYS-1:0][TAG_W-1:0]  row_tag_i,
  input  logic [WAYS-1:0][AGE_W-1:0]  row_age_i,
  output logic [WAYS-1:0]             new_valid_o,
  output logic [WAYS-1:0][TAG_W-1:0]  new_tag_o,
  output logic [WAYS-1:0][AGE_W-1:0]  new_age_o,
  output salc_stat_t                  stat_o
);

  localparam int WIDX_W = (WAYS > 1) ? $clog2(WAYS) : 1;

  logic [WAYS-1:0]   used;
  logic [WAYS-1:0]   hit_vec;
  logic              hit;
  logic [WIDX_W-1:0] hit_idx;
  logic              any_free;
  logic [WIDX_W-1:0] free_idx;
  logic [AGE_W-1:0]  best;
  logic [WIDX_W-1:0] lru_idx;
  logic [WIDX_W-1:0] victim;
  logic [AGE_W-1:0]  hit_rank;

  always_comb begin
    hit      = 1'b0;
    hit_idx  = '0;
    any_free = 1'b0;
    free_idx = '0;
    for (int w = 0; w < WAYS; w++) begin
      used[w]    = WCNT_W'(w) < ways_i;
      hit_vec[w] = used[w] && row_valid_i[w] && (row_tag_i[w] == tag_i);
    end
    // lowest index wins
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (hit_vec[w]) begin
        hit     = 1'b1;
        hit_idx = WIDX_W'(w);
      end
      if (used[w] && !row_valid_i[w]) begin
        any_free = 1'b1;
        free_idx = WIDX_W'(w);
      end
    end
    // largest rank, first one on a tie
    best    = '0;
    lru_idx = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (used[w] && (row_age_i[w] > best)) begin
        best    = row_age_i[w];
        lru_idx = WIDX_W'(w);
      end
    end
    victim   = any_free ? free_idx : lru_idx;
    hit_rank = row_age_i[hit_idx];

    new_valid_o = row_valid_i;
    new_tag_o   = row_tag_i;
    new_age_o   = row_age_i;
    if (access_i) begin
      if (hit) begin
        for (int w = 0; w < WAYS; w++) begin
          if ((WIDX_W'(w) != hit_idx) && used[w] && row_valid_i[w] &&
              (row_age_i[w] < hit_rank)) begin
            new_age_o[w] = age_inc(row_age_i[w]);
          end
        end
        new_age_o[hit_idx] = '0;
      end else begin
        for (int w = 0; w < WAYS; w++) begin
          if ((WIDX_W'(w) != victim) && used[w] && row_valid_i[w]) begin
            new_age_o[w] = age_inc(row_age_i[w]);
          end
        end
        new_valid_o[victim] = 1'b1;
        new_tag_o[victim]   = tag_i;
        new_age_o[victim]   = '0;
      end
    end

    stat_o.hit   = access_i && hit;
    stat_o.evict = access_i && !hit && !any_free;
  end

endmodule

@@ hw/rtl/set_assoc_lru_cache_sim.sv @@
// Set-associative LRU cache simulator: top level with control, totals and
// result register. Uses salc_pkg, salc_row_store and salc_lru_update.
//
// Each input item (action, address) is split into set and tag by the
// set_bits and block_bits registers; the set's row (valid, tag, recency rank
// of every way) is read from a single-port-read memory, searched and updated,
// and written back, giving one result item with this item's hit, miss and
// eviction flags and the saturating running totals. The accept issues the row
// read; the updated row is then written back and the result register loaded
// once the result register has room; tready is low from accept until then,
// so a new item is not taken before the current one is done. This is set by
// the registered read of the row memory followed by the read-modify-write of
// the same row. A modify is two accesses handled in the same pass (its second
// access always hits). If the result register is still full when an item
// finishes, the write-back waits until the result is taken. After reset the
// block clears the valid bits and ranks of all 2**MAX_SET_BITS rows, one row
// per cycle, with tready low; configuration writes are taken at any time.
// Changing the geometry does not flush stored lines.
// Configuration is meant to be written only while no item is in flight.
`timescale 1ns / 1ps

module set_assoc_lru_cache_sim
  import salc_pkg::*;
#(
  parameter int MAX_SET_BITS  = 6,
  parameter int MAX_WAYS      = 8,
  parameter int ADDRESS_WIDTH = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // input items
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [1:0] action, [33:2] address
  // result items
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [1:0] hits_now, [2] missed,
                                                 // [3] evicted, [35:4] hit_sum,
                                                 // [67:36] miss_sum,
                                                 // [99:68] eviction_sum
  // configuration writes
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata_i
);

  // Effective address width: the address field is 32 bits wide
  localparam int EAW    = (ADDRESS_WIDTH < ADDR_W) ? ADDRESS_WIDTH : ADDR_W;
  localparam int ROWS   = 2 ** MAX_SET_BITS;
  localparam int SETW   = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int SB_W   = $clog2(MAX_SET_BITS + 1) + 1;
  localparam int SH_W   = $clog2(MAX_SET_BITS + BLK_BITS_W + 32) + 1;
  localparam int WCNT_W = $clog2(MAX_WAYS + 1) + 1;

  // ---------------------------------------------------------------------
  // Config registers
  // ---------------------------------------------------------------------
  logic [SET_BITS_W-1:0] set_bits_q;
  logic [WAYS_CFG_W-1:0] ways_q;
  logic [BLK_BITS_W-1:0] blk_bits_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_bits_q <= '0;
      ways_q     <= WAYS_CFG_W'(1);
      blk_bits_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SET_BITS:   set_bits_q <= cfg_wdata_i[SET_BITS_W-1:0];
        CFG_WAYS:       ways_q     <= cfg_wdata_i[WAYS_CFG_W-1:0];
        CFG_BLOCK_BITS: blk_bits_q <= cfg_wdata_i[BLK_BITS_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp out-of-range geometry
  logic [SB_W-1:0]   sb_eff;
  logic [WCNT_W-1:0] ways_eff;
  logic [SH_W-1:0]   split;

  always_comb begin
    sb_eff = (int'(set_bits_q) > MAX_SET_BITS) ? SB_W'(MAX_SET_BITS) : SB_W'(set_bits_q);
    if (ways_q == '0) begin
      ways_eff = WCNT_W'(1);
    end else if (int'(ways_q) > MAX_WAYS) begin
      ways_eff = WCNT_W'(MAX_WAYS);
    end else begin
      ways_eff = WCNT_W'(ways_q);
    end
    split = SH_W'(sb_eff) + SH_W'(blk_bits_q);
  end

  // ---------------------------------------------------------------------
  // Address split of the incoming item
  // ---------------------------------------------------------------------
  logic [EAW-1:0]  in_addr;
  logic [EAW-1:0]  in_tag;
  logic [EAW-1:0]  in_set_full;
  logic [SETW-1:0] in_set;

  always_comb begin
    in_addr     = s_axis_tdata[IN_ADDR_LSB +: EAW];
    in_tag      = in_addr >> split;       // zero once the split covers the address
    in_set_full = in_addr >> blk_bits_q;
    in_set      = in_set_full[SETW-1:0] & ~({SETW{1'b1}} << sb_eff);
  end

  // ---------------------------------------------------------------------
  // Control
  // ---------------------------------------------------------------------
  salc_state_e state_q, state_d;
  logic [SETW-1:0] clr_cnt_q, clr_cnt_d;
  logic            in_acc;
  logic            fire;

  logic                     m_valid_q, m_valid_d;
  salc_action_e             act_q;
  logic [EAW-1:0]           tag_q;
  logic [SETW-1:0]          set_q;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign fire          = (state_q == ST_EXEC) && (!m_valid_q || m_axis_tready);

  always_comb begin
    state_d   = state_q;
    clr_cnt_d = clr_cnt_q;
    case (state_q)
      ST_CLEAR: begin
        clr_cnt_d = clr_cnt_q + SETW'(1);
        if (clr_cnt_q == SETW'(ROWS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (fire) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_cnt_q <= '0;
    end else begin
      state_q   <= state_d;
      clr_cnt_q <= clr_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      act_q <= salc_action_e'(s_axis_tdata[ACTION_W-1:0]);
      tag_q <= in_tag;
      set_q <= in_set;
    end
  end

  // ---------------------------------------------------------------------
  // Row memory and update logic
  // ---------------------------------------------------------------------
  logic [MAX_WAYS-1:0]                rd_valid, new_valid, wr_valid;
  logic [MAX_WAYS-1:0][EAW-1:0]       rd_tag, new_tag, wr_tag;
  logic [MAX_WAYS-1:0][AGE_W-1:0]     rd_age, new_age, wr_age;
  logic                               access;
  logic                               wr_en;
  logic [SETW-1:0]                    wr_addr;
  salc_stat_t                         stat;

  assign access = (act_q != ACT_NONE);

  salc_row_store #(
    .ROWS  (ROWS),
    .IDX_W (SETW),
    .WAYS  (MAX_WAYS),
    .TAG_W (EAW)
  ) u_store (
    .clk_i      (clk_i),
    .rd_en_i    (in_acc),
    .rd_addr_i  (in_set),
    .wr_en_i    (wr_en),
    .wr_addr_i  (wr_addr),
    .wr_valid_i (wr_valid),
    .wr_tag_i   (wr_tag),
    .wr_age_i   (wr_age),
    .rd_valid_o (rd_valid),
    .rd_tag_o   (rd_tag),
    .rd_age_o   (rd_age)
  );

  salc_lru_update #(
    .WAYS   (MAX_WAYS),
    .TAG_W  (EAW),
    .WCNT_W (WCNT_W)
  ) u_update (
    .access_i    (access),
    .tag_i       (tag_q),
    .ways_i      (ways_eff),
    .row_valid_i (rd_valid),
    .row_tag_i   (rd_tag),
    .row_age_i   (rd_age),
    .new_valid_o (new_valid),
    .new_tag_o   (new_tag),
    .new_age_o   (new_age),
    .stat_o      (stat)
  );

  // Clear pass zeroes valid and rank; otherwise write back the updated row
  always_comb begin
    if (state_q == ST_CLEAR) begin
      wr_en    = 1'b1;
      wr_addr  = clr_cnt_q;
      wr_valid = '0;
      wr_tag   = '0;
      wr_age   = '0;
    end else begin
      wr_en    = fire && access;
      wr_addr  = set_q;
      wr_valid = new_valid;
      wr_tag   = new_tag;
      wr_age   = new_age;
    end
  end

  // ---------------------------------------------------------------------
  // Totals and result register
  // ---------------------------------------------------------------------
  logic [HITS_W-1:0] hits_now;
  logic              missed, evicted;
  logic [SUM_W-1:0]  hit_sum_q, hit_sum_d;
  logic [SUM_W-1:0]  miss_sum_q, miss_sum_d;
  logic [SUM_W-1:0]  evict_sum_q, evict_sum_d;
  logic [SUM_W:0]    hit_add, miss_add, evict_add;
  logic [OUT_TDATA_W-1:0] out_q;

  always_comb begin
    // a modify counts one more hit from its second access
    hits_now = HITS_W'(stat.hit) + HITS_W'(act_q == ACT_MODIFY);
    missed   = access && !stat.hit;
    evicted  = stat.evict;

    hit_add   = {1'b0, hit_sum_q} + (SUM_W + 1)'(hits_now);
    miss_add  = {1'b0, miss_sum_q} + (SUM_W + 1)'(missed);
    evict_add = {1'b0, evict_sum_q} + (SUM_W + 1)'(evicted);

    hit_sum_d   = hit_add[SUM_W]   ? '1 : hit_add[SUM_W-1:0];
    miss_sum_d  = miss_add[SUM_W]  ? '1 : miss_add[SUM_W-1:0];
    evict_sum_d = evict_add[SUM_W] ? '1 : evict_add[SUM_W-1:0];

    m_valid_d = m_valid_q;
    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end
    if (fire) begin
      m_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q   <= 1'b0;
      hit_sum_q   <= '0;
      miss_sum_q  <= '0;
      evict_sum_q <= '0;
    end else begin
      m_valid_q <= m_valid_d;
      if (fire) begin
        hit_sum_q   <= hit_sum_d;
        miss_sum_q  <= miss_sum_d;
        evict_sum_q <= evict_sum_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= {4'b0, evict_sum_d, miss_sum_d, hit_sum_d, evicted, missed, hits_now};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = out_q;

endmodule

@@ hw/rtl/salc_checker.sv @@
// Port-level assertions for set_assoc_lru_cache_sim, bound to the top level.
// Uses salc_pkg and the macros of set_assoc_lru_cache_sim_defines.svh.
`timescale 1ns / 1ps
`include "set_assoc_lru_cache_sim_defines.svh"

module salc_checker
  import salc_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_axis_tvalid,
  input logic                   s_axis_tready,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  // stalled result holds
  `SALC_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")

  // one item in flight: busy for the cycle after an accept
  `SALC_ASSERT(a_busy_after_accept, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "item accepted during read-modify-write")

  // an eviction only happens on a miss
  `SALC_NEVER(a_evict_needs_miss, m_axis_tvalid && m_axis_tdata[3] && !m_axis_tdata[2], "eviction without miss")

  // a miss allows at most the one hit of a modify's second access
  `SALC_NEVER(a_hits_range, m_axis_tvalid && (m_axis_tdata[1:0] == 2'd3 || (m_axis_tdata[2] && m_axis_tdata[1:0] == 2'd2)), "hit count out of range")

endmodule

bind set_assoc_lru_cache_sim salc_checker u_salc_checker (.*);
